>>> rtl/arpc_pkg.sv
package arpc_pkg;

  // Field widths
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;

  // Default table depth
  localparam int DEF_ENTRIES = 16;

  // Operation codes on in_func
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

endpackage

>>> rtl/arpc_cell.sv
// One table slot plus one stage of the search chain. The search record
// passes through every cell, one cell per cycle, and each cell folds its
// own slot into the running match, empty-slot and oldest-slot picks.
module arpc_cell #(
  parameter int ENTRIES = arpc_pkg::DEF_ENTRIES,
  parameter int IDX     = 0,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [1 + 1 + arpc_pkg::IP_W + arpc_pkg::MAC_W + 1 + IDX_W + arpc_pkg::MAC_W
                + 1 + IDX_W + IDX_W + arpc_pkg::STAMP_W - 1:0] scan_i,
  output logic [1 + 1 + arpc_pkg::IP_W + arpc_pkg::MAC_W + 1 + IDX_W + arpc_pkg::MAC_W
                + 1 + IDX_W + IDX_W + arpc_pkg::STAMP_W - 1:0] scan_o,
  input  logic [1 + 1 + IDX_W + arpc_pkg::IP_W + arpc_pkg::MAC_W
                + arpc_pkg::STAMP_W - 1:0] wr_i
);

  // Search record carried along the chain
  typedef struct packed {
    logic                          vld;
    logic                          func;
    logic [arpc_pkg::IP_W-1:0]     ip;
    logic [arpc_pkg::MAC_W-1:0]    mac;
    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [arpc_pkg::MAC_W-1:0]    hit_mac;
    logic                          emp;
    logic [IDX_W-1:0]              emp_idx;
    logic [IDX_W-1:0]              best_idx;
    logic [arpc_pkg::STAMP_W-1:0]  best_stamp;
  } scan_t;

  // Write-back broadcast
  typedef struct packed {
    logic                          en;
    logic                          fresh;
    logic [IDX_W-1:0]              idx;
    logic [arpc_pkg::IP_W-1:0]     ip;
    logic [arpc_pkg::MAC_W-1:0]    mac;
    logic [arpc_pkg::STAMP_W-1:0]  stamp;
  } wr_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  scan_t                         scan_in;
  scan_t                         scan_nxt;
  scan_t                         scan_r;
  wr_t                           wr;
  logic                          valid_r;
  logic [arpc_pkg::IP_W-1:0]     ip_r;
  logic [arpc_pkg::MAC_W-1:0]    mac_r;
  logic [arpc_pkg::STAMP_W-1:0]  stamp_r;
  logic                          wr_me;

  assign scan_in = scan_i;
  assign wr      = wr_i;
  assign scan_o  = scan_r;
  assign wr_me   = wr.en && (wr.idx == MY_IDX);

  // Fold this slot into the record
  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.hit && valid_r && (ip_r == scan_in.ip)) begin
      scan_nxt.hit     = 1'b1;
      scan_nxt.hit_idx = MY_IDX;
      scan_nxt.hit_mac = mac_r;
    end
    if (!scan_in.emp && !valid_r) begin
      scan_nxt.emp     = 1'b1;
      scan_nxt.emp_idx = MY_IDX;
    end
    // strict compare keeps the lowest index on ties
    if (stamp_r < scan_in.best_stamp) begin
      scan_nxt.best_idx   = MY_IDX;
      scan_nxt.best_stamp = stamp_r;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  // Slot valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_me && wr.fresh) begin
      valid_r <= 1'b1;
    end
  end

  // Slot contents; IP and MAC only read while valid, the stamp always compared
  always_ff @(posedge clk) begin
    if (wr_me) begin
      mac_r   <= wr.mac;
      stamp_r <= wr.stamp;
      if (wr.fresh) begin
        ip_r <= wr.ip;
      end
    end
  end

endmodule

>>> rtl/arp_cache_oldest_replace_top.sv
// ARP cache: fully associative IPv4 -> MAC table with oldest-entry replacement.
// Input channel (in_valid/in_ready) takes one word: in_func selects add
// (FUNC_ADD) or lookup (FUNC_LOOKUP), with in_ip_addr and in_mac_in.
// Every input word yields exactly one output word on out_valid/out_ready:
// out_hit and out_mac_out (both zero for adds and for lookup misses).
// The search record walks a chain of ENTRIES slot cells, one cell per cycle;
// at the tail the write-back is applied and the output register loaded.
// Only one word is in the cell chain at a time: a new input word is not
// accepted until the previous one has left the chain.
// A finished word waits in the output register; the next input word may be
// accepted in the same cycle that word is taken. While the receiver stalls,
// in_ready stays low and the table is unchanged.
// Reset (rst_n low, synchronous) empties the table, clears the stamp counter
// and drops any word in flight.
module arp_cache_oldest_replace_top #(
  parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [arpc_pkg::IP_W-1:0]    in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0]   in_mac_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [arpc_pkg::MAC_W-1:0]   out_mac_out
);

  localparam int IDX_W = $clog2(ENTRIES);

  typedef struct packed {
    logic                          vld;
    logic                          func;
    logic [arpc_pkg::IP_W-1:0]     ip;
    logic [arpc_pkg::MAC_W-1:0]    mac;
    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [arpc_pkg::MAC_W-1:0]    hit_mac;
    logic                          emp;
    logic [IDX_W-1:0]              emp_idx;
    logic [IDX_W-1:0]              best_idx;
    logic [arpc_pkg::STAMP_W-1:0]  best_stamp;
  } scan_t;

  typedef struct packed {
    logic                          en;
    logic                          fresh;
    logic [IDX_W-1:0]              idx;
    logic [arpc_pkg::IP_W-1:0]     ip;
    logic [arpc_pkg::MAC_W-1:0]    mac;
    logic [arpc_pkg::STAMP_W-1:0]  stamp;
  } wr_t;

  scan_t                         link [ENTRIES+1];
  scan_t                         tail;
  wr_t                           wb;
  logic [ENTRIES-1:0]            chain_vld;
  logic                          in_fire;
  logic                          out_fire;
  logic                          busy_r;
  logic                          busy_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_hit_r;
  logic [arpc_pkg::MAC_W-1:0]    out_mac_r;
  logic [arpc_pkg::STAMP_W-1:0]  stamp_cnt_r;
  logic [arpc_pkg::STAMP_W-1:0]  stamp_cnt_nxt;
  logic                          res_hit;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = !busy_r && (!out_valid_r || out_ready);

  // Fresh search record enters the first cell
  always_comb begin
    link[0].vld        = in_fire;
    link[0].func       = in_func;
    link[0].ip         = in_ip_addr;
    link[0].mac        = in_mac_in;
    link[0].hit        = 1'b0;
    link[0].hit_idx    = '0;
    link[0].hit_mac    = '0;
    link[0].emp        = 1'b0;
    link[0].emp_idx    = '0;
    link[0].best_idx   = '0;
    link[0].best_stamp = '1;
  end

  // Chain of slot cells
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    arpc_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .scan_i (link[k]),
      .scan_o (link[k+1]),
      .wr_i   (wb)
    );
    assign chain_vld[k] = link[k+1].vld;
  end

  assign tail = link[ENTRIES];

  // Write-back: refresh a hit, else fill lowest empty, else replace oldest
  always_comb begin
    wb.en    = tail.vld && (tail.func == arpc_pkg::FUNC_ADD);
    wb.fresh = !tail.hit;
    wb.ip    = tail.ip;
    wb.mac   = tail.mac;
    wb.stamp = stamp_cnt_r;
    if (tail.hit) begin
      wb.idx = tail.hit_idx;
    end else if (tail.emp) begin
      wb.idx = tail.emp_idx;
    end else begin
      wb.idx = tail.best_idx;
    end
  end

  assign res_hit = (tail.func == arpc_pkg::FUNC_LOOKUP) && tail.hit;

  // Control next state
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    stamp_cnt_nxt = stamp_cnt_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      busy_nxt = 1'b1;
    end
    if (tail.vld) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (wb.en) begin
      stamp_cnt_nxt = stamp_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      stamp_cnt_r <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (tail.vld) begin
      out_hit_r <= res_hit;
      out_mac_r <= res_hit ? tail.hit_mac : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_mac_out = out_mac_r;

  // At most one word in the chain
  a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one word in the search chain");

  // A word only enters an empty chain
  a_enter_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (chain_vld == '0))
    else $error("word accepted while chain busy");

  // A finished word never lands on a stalled output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken output word");

  // Each add advances the stamp by one
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    wb.en |=> (stamp_cnt_r == $past(stamp_cnt_r) + 1'b1))
    else $error("stamp counter did not advance on add");

endmodule

>>> sim/arp_cache_checker.sv
// Watches both channels of the ARP cache, keeps its own copy of the table,
// and compares every output word with the oldest predicted word.
module arp_cache_checker #(
  parameter int ENTRIES = arpc_pkg::DEF_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_func,
  input  logic [arpc_pkg::IP_W-1:0]  in_ip_addr,
  input  logic [arpc_pkg::MAC_W-1:0] in_mac_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_hit,
  input  logic [arpc_pkg::MAC_W-1:0] out_mac_out,
  output int                         mismatches,
  output int                         pending,
  output int                         words_in,
  output int                         lookups_in,
  output int                         hits_out,
  output int                         evictions
);

  typedef struct packed {
    logic                       hit;
    logic [arpc_pkg::MAC_W-1:0] mac;
  } lookup_word_t;

  // Shadow table
  logic [arpc_pkg::IP_W-1:0]    tbl_ip    [ENTRIES];
  logic [arpc_pkg::MAC_W-1:0]   tbl_mac   [ENTRIES];
  logic [arpc_pkg::STAMP_W-1:0] tbl_stamp [ENTRIES];
  logic                         tbl_used  [ENTRIES];
  logic [arpc_pkg::STAMP_W-1:0] stamp_next;

  lookup_word_t expected_words[$];

  // Apply one word to the shadow table and return the word it should produce
  task automatic cache_apply(input logic func, input logic [arpc_pkg::IP_W-1:0] ip,
                             input logic [arpc_pkg::MAC_W-1:0] mac,
                             output lookup_word_t res);
    int slot;
    int best;
    slot = -1;
    for (int k = 0; k < ENTRIES; k++)
      if (slot < 0 && tbl_used[k] && tbl_ip[k] == ip) slot = k;
    res.hit = 1'b0;
    res.mac = '0;
    if (func == arpc_pkg::FUNC_ADD) begin
      if (slot < 0) begin
        // empty slots first, then the smallest stamp, lowest index on ties
        for (int k = 0; k < ENTRIES; k++)
          if (slot < 0 && !tbl_used[k]) slot = k;
        if (slot < 0) begin
          best = 0;
          for (int k = 1; k < ENTRIES; k++)
            if (tbl_stamp[k] < tbl_stamp[best]) best = k;
          slot = best;
          evictions++;
        end
        tbl_ip[slot]   = ip;
        tbl_used[slot] = 1'b1;
      end
      tbl_mac[slot]   = mac;
      tbl_stamp[slot] = stamp_next;
      stamp_next      = stamp_next + 1'b1;
    end else if (slot >= 0) begin
      res.hit = 1'b1;
      res.mac = tbl_mac[slot];
    end
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk) begin : mon
    lookup_word_t pred;
    lookup_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        tbl_ip[k]    = '0;
        tbl_mac[k]   = '0;
        tbl_stamp[k] = '0;
        tbl_used[k]  = 1'b0;
      end
      stamp_next = '0;
      expected_words.delete();
      mismatches = 0;
      pending    = 0;
      words_in   = 0;
      lookups_in = 0;
      hits_out   = 0;
      evictions  = 0;
    end else begin
      if (in_valid && in_ready) begin
        cache_apply(in_func, in_ip_addr, in_mac_in, pred);
        expected_words.push_back(pred);
        words_in++;
        if (in_func == arpc_pkg::FUNC_LOOKUP) lookups_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: output word with none expected: hit=%0b mac=%012h",
                     out_hit, out_mac_out);
        end else begin
          want = expected_words.pop_front();
          if (out_hit !== want.hit || out_mac_out !== want.mac) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: word mismatch: expected hit=%0b mac=%012h, ",
                        "got hit=%0b mac=%012h"},
                       want.hit, want.mac, out_hit, out_mac_out);
          end
          if (out_hit === 1'b1) hits_out++;
        end
      end
      pending = expected_words.size();
    end
  end

endmodule

>>> sim/tb_arp_cache_oldest_replace_top.sv
module tb_arp_cache_oldest_replace_top;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_func     = arpc_pkg::FUNC_ADD;
  logic [arpc_pkg::IP_W-1:0]  in_ip_addr  = '0;
  logic [arpc_pkg::MAC_W-1:0] in_mac_in   = '0;
  logic                       out_ready   = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic                       out_hit;
  logic [arpc_pkg::MAC_W-1:0] out_mac_out;

  // Both sides stop idling while this is set
  logic no_idle = 1'b0;

  int mismatches, pending, words_in, lookups_in, hits_out, evictions;

  logic [arpc_pkg::IP_W-1:0] addr_pool [24];

  arp_cache_oldest_replace_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_ip_addr  (in_ip_addr),
    .in_mac_in   (in_mac_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hit     (out_hit),
    .out_mac_out (out_mac_out)
  );

  arp_cache_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_ip_addr  (in_ip_addr),
    .in_mac_in   (in_mac_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hit     (out_hit),
    .out_mac_out (out_mac_out),
    .mismatches  (mismatches),
    .pending     (pending),
    .words_in    (words_in),
    .lookups_in  (lookups_in),
    .hits_out    (hits_out),
    .evictions   (evictions)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Timeout: run did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[arpc_pkg::MAC_W-1:0];
  endfunction

  // Offer one word, optionally after an idle gap, and wait until it is taken
  task automatic send_word(input logic func, input logic [arpc_pkg::IP_W-1:0] ip,
                           input logic [arpc_pkg::MAC_W-1:0] mac);
    if (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_ip_addr <= ip;
    in_mac_in  <= mac;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random stalls plus one long hold-off once traffic is flowing
  initial begin : rx
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_in >= 300) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 28);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stim
    int  r;
    logic func;
    logic [arpc_pkg::IP_W-1:0] ip;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, address extremes, refresh, fill and evict
    send_word(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, rand_mac());  // empty slot vs 0.0.0.0
    send_word(arpc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, rand_mac());
    send_word(arpc_pkg::FUNC_ADD,    32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_word(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0);
    send_word(arpc_pkg::FUNC_ADD,    32'hFFFF_FFFF, 48'h0);
    send_word(arpc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(arpc_pkg::FUNC_ADD,    32'h0000_0000, 48'h1234_5678_9ABC);  // refresh
    send_word(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, rand_mac());
    for (int k = 1; k <= 14; k++)
      send_word(arpc_pkg::FUNC_ADD, {8'd10, 16'd0, k[7:0]}, rand_mac());
    // table full: the stalest entry (255.255.255.255) goes
    send_word(arpc_pkg::FUNC_ADD,    32'hC0A8_0001, rand_mac());
    send_word(arpc_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, rand_mac());
    send_word(arpc_pkg::FUNC_LOOKUP, 32'h0000_0000, rand_mac());

    // Random: mostly a pool wider than the table, some fully random words
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 24; k++) addr_pool[k] = $urandom;
    for (int n = 0; n < 1000; n++) begin
      no_idle <= (n >= 500 && n < 650);
      r = $urandom_range(99);
      if (r < 10) begin
        func = 1'($urandom_range(1));
        ip   = $urandom;
      end else begin
        func = ($urandom_range(99) < 45) ? arpc_pkg::FUNC_ADD : arpc_pkg::FUNC_LOOKUP;
        ip   = addr_pool[$urandom_range(23)];
      end
      send_word(func, ip, rand_mac());
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    // Drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d words: %0d adds, %0d lookups, %0d lookup hits", words_in,
             words_in - lookups_in, lookups_in, hits_out);
    $display("Oldest-entry replacements exercised: %0d; mismatches: %0d, left over: %0d",
             evictions, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_cache_oldest_replace_top.sv
sim/arp_cache_checker.sv
sim/tb_arp_cache_oldest_replace_top.sv
